// File: src/mfs_pkg.sv
package mfs_pkg;

  localparam int MAX_NEURONS     = 8;
  localparam int NUM_LAYERS      = 3;
  localparam int SIGMOID_ENTRIES = 256;
  localparam int NIDX_W          = $clog2(MAX_NEURONS);
  localparam int CNT_W           = 4;
  localparam int SIG_IDX_W       = $clog2(SIGMOID_ENTRIES);
  localparam int ACT_W           = 13;
  localparam int VAL_W           = 16;
  localparam int PROD_W          = 2 * VAL_W;
  localparam int ACC_W           = VAL_W + 8;
  localparam int CNT_CAP         = (MAX_NEURONS < 8) ? MAX_NEURONS : 8;

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_INPUT  = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  localparam logic [1:0] LAYER_HIDDEN = 2'd1;
  localparam logic [1:0] LAYER_OUTPUT = 2'd2;

  localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] REG_HIDDEN_COUNT = 2'd1;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd2;

  localparam longint unsigned Q30 = 64'd1 << 30;

  typedef struct packed {
    logic [1:0]              command;
    logic [1:0]              target_layer;
    logic [2:0]              neuron_index;
    logic [2:0]              source_index;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0] activation;
    logic [2:0]       output_neuron;
    logic             last;
  } out_item_t;

  // Per-cycle command broadcast along the cell row
  typedef struct packed {
    logic                    clear;
    logic                    mac_en;
    logic                    layer;
    logic [NIDX_W-1:0]       src;
    logic signed [VAL_W-1:0] src_val;
    logic                    shift;
  } cell_ctrl_t;

  // Weight write into one cell's local store
  typedef struct packed {
    logic                    en;
    logic                    layer;
    logic [NIDX_W-1:0]       src;
    logic signed [VAL_W-1:0] val;
  } wt_wr_t;

  typedef logic [ACT_W-1:0] sig_tab_t [SIGMOID_ENTRIES];

  // Clamp a count into 1..CNT_CAP
  function automatic logic [CNT_W-1:0] eff_count(logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) r = CNT_W'(1);
    else if (c > CNT_W'(CNT_CAP)) r = CNT_W'(CNT_CAP);
    return r;
  endfunction

  // Restoring long division, only evaluated while the table is built
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[62:0], a[j]};
      if (r >= b) begin
        r    = r - b;
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-f) in Q30, truncated Taylor series
  function automatic longint unsigned exp_neg_q30(longint unsigned f);
    longint signed   sum;
    longint unsigned term;
    sum  = longint'(Q30);
    term = Q30;
    for (int k = 1; k <= 20; k++) begin
      term = udiv64(term * f, 64'(k) << 30);
      if (k[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  function automatic logic [ACT_W-1:0] sig_entry(int i);
    longint signed   x;
    longint unsigned t;
    longint unsigned whole;
    longint unsigned e;
    longint unsigned e1;
    longint unsigned den;
    longint unsigned num;
    longint unsigned q;
    x = -(longint'(1) <<< 23) + ((longint'(2 * i + 1) <<< 23) >>> SIG_IDX_W);
    t = (x < 0) ? longint'(-x) : longint'(x);
    whole = t >> 20;
    e  = exp_neg_q30((t & 64'hFFFFF) << 10);
    e1 = exp_neg_q30(Q30);
    for (int k = 0; k < 8; k++) begin
      if (longint'(k) < whole) e = (e * e1) >> 30;
    end
    den = Q30 + e;
    num = (x >= 0) ? (Q30 << 12) : (e << 12);
    q = udiv64(num + (den >> 1), den);
    return q[ACT_W-1:0];
  endfunction

  function automatic sig_tab_t build_sig_table();
    sig_tab_t tab;
    for (int i = 0; i < SIGMOID_ENTRIES; i++) tab[i] = sig_entry(i);
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

// File: src/mlp_forward_sigmoid_core.sv
// Write items are taken whenever the block is idle; one item is in work at a time.
// A run goes, per layer, through one MAC step per source neuron, one flush step
// and one drain step per neuron; output drain steps wait while the receiver stalls.
// Reset (asynchronous, active low) clears control and counts to 3/2/1;
// weight and input stores hold nothing defined until written.
module mlp_forward_sigmoid_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mfs_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mfs_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [3:0]         cfg_data_i
);
  import mfs_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_FLUSH, ST_DRAIN} state_e;

  state_e            state_q;
  logic              layer_q;
  logic [NIDX_W-1:0] cnt_q;
  logic [CNT_W-1:0]  in_cnt_q, hid_cnt_q, out_cnt_q;
  logic              out_valid_q;
  logic              out_valid_d;
  out_item_t         out_q;

  logic signed [VAL_W-1:0] in_store_q  [MAX_NEURONS];
  logic signed [VAL_W-1:0] hid_store_q [MAX_NEURONS];

  logic signed [ACC_W-1:0] acc   [MAX_NEURONS];
  logic signed [ACC_W-1:0] chain [MAX_NEURONS];
  cell_ctrl_t              ctrl;
  wt_wr_t                  wr [MAX_NEURONS];
  logic [ACT_W-1:0]        act;

  logic             in_acc, run_go, advance, src_last, drain_last;
  logic [CNT_W-1:0] ni, nh, no, pcnt, dcnt;
  logic             wt_ok;

  assign ni = eff_count(in_cnt_q);
  assign nh = eff_count(hid_cnt_q);
  assign no = eff_count(out_cnt_q);
  localparam bit THREE_LAYER = (NUM_LAYERS >= 3);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign run_go     = in_acc && (in_data_i.command == CMD_RUN);
  assign cfg_ready_o = 1'b1;

  assign pcnt = (layer_q && THREE_LAYER) ? nh : ni;
  assign dcnt = layer_q ? no : nh;
  assign src_last   = ({1'b0, cnt_q} == pcnt - CNT_W'(1));
  assign drain_last = ({1'b0, cnt_q} == dcnt - CNT_W'(1));
  assign advance    = (state_q == ST_DRAIN) && (!layer_q || !out_valid_q || !out_stall_i);

  // Raise valid on an output drain step, hold it while stalled
  assign out_valid_d = (advance && layer_q) || (out_valid_q && out_stall_i);

  // Broadcast command to the cells
  always_comb begin
    ctrl.clear  = run_go || (advance && !layer_q && drain_last);
    ctrl.mac_en = (state_q == ST_MAC);
    ctrl.layer  = layer_q;
    ctrl.src    = cnt_q;
    ctrl.src_val = (layer_q && THREE_LAYER) ? hid_store_q[cnt_q] : in_store_q[cnt_q];
    ctrl.shift  = advance;
  end

  assign wt_ok = in_acc && (in_data_i.command == CMD_WEIGHT)
                 && ((in_data_i.target_layer == LAYER_HIDDEN)
                     || (in_data_i.target_layer == LAYER_OUTPUT));

  // Build the neuron cell row
  for (genvar g = 0; g < MAX_NEURONS; g++) begin : g_cell
    always_comb begin
      wr[g].en    = wt_ok && (32'(in_data_i.neuron_index) == g)
                    && (32'(in_data_i.source_index) < MAX_NEURONS);
      wr[g].layer = (in_data_i.target_layer == LAYER_OUTPUT);
      wr[g].src   = in_data_i.source_index[NIDX_W-1:0];
      wr[g].val   = in_data_i.value;
    end
    if (g == MAX_NEURONS - 1) begin : g_end
      assign chain[g] = '0;
    end else begin : g_mid
      assign chain[g] = acc[g+1];
    end
    mfs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .wr_i   (wr[g]),
      .shift_i(chain[g]),
      .acc_o  (acc[g])
    );
  end

  mfs_act u_act (
    .acc_i(acc[0]),
    .act_o(act)
  );

  // Hold input values and hidden activations
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_data_i.command == CMD_INPUT)
        && (32'(in_data_i.neuron_index) < MAX_NEURONS)) begin
      in_store_q[in_data_i.neuron_index[NIDX_W-1:0]] <= in_data_i.value;
    end
    if (advance && !layer_q) hid_store_q[cnt_q] <= {3'b000, act};
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= CNT_W'(3);
      hid_cnt_q <= CNT_W'(2);
      out_cnt_q <= CNT_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_INPUT_COUNT:  in_cnt_q  <= cfg_data_i;
        REG_HIDDEN_COUNT: hid_cnt_q <= cfg_data_i;
        REG_OUTPUT_COUNT: out_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequence the layers and registered output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      layer_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (run_go) begin
            state_q <= ST_MAC;
            layer_q <= !THREE_LAYER;
            cnt_q   <= '0;
          end
        end
        ST_MAC: begin
          if (src_last) begin
            state_q <= ST_FLUSH;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + NIDX_W'(1);
          end
        end
        ST_FLUSH: state_q <= ST_DRAIN;
        ST_DRAIN: begin
          if (advance) begin
            if (layer_q) begin
              out_q.activation    <= act;
              out_q.output_neuron <= 3'(cnt_q);
              out_q.last          <= drain_last;
            end
            if (drain_last) begin
              cnt_q   <= '0;
              state_q <= layer_q ? ST_IDLE : ST_MAC;
              layer_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q + NIDX_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/mfs_cell.sv
module mfs_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mfs_pkg::cell_ctrl_t              ctrl_i,
  input  mfs_pkg::wt_wr_t                  wr_i,
  input  logic signed [mfs_pkg::ACC_W-1:0] shift_i,
  output logic signed [mfs_pkg::ACC_W-1:0] acc_o
);
  import mfs_pkg::*;

  logic signed [VAL_W-1:0]  wt_q [2*MAX_NEURONS];
  logic signed [PROD_W-1:0] prod_q;
  logic                     pv_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [ACC_W-1:0]  term;

  // Hold this neuron's weights for both layers
  always_ff @(posedge clk_i) begin
    if (wr_i.en) wt_q[{wr_i.layer, wr_i.src}] <= wr_i.val;
  end

  assign prod_d = wt_q[{ctrl_i.layer, ctrl_i.src}] * ctrl_i.src_val;
  assign term   = ACC_W'(prod_q >>> 12);

  // Register product, then clear, accumulate or take neighbor's sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      pv_q <= ctrl_i.mac_en;
      if (ctrl_i.clear) acc_q <= '0;
      else if (pv_q) acc_q <= acc_q + term;
      else if (ctrl_i.shift) acc_q <= shift_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mac_en) prod_q <= prod_d;
  end

  assign acc_o = acc_q;

endmodule

// File: src/mfs_act.sv
module mfs_act (
  input  logic signed [mfs_pkg::ACC_W-1:0] acc_i,
  output logic [mfs_pkg::ACT_W-1:0]        act_o
);
  import mfs_pkg::*;

  logic signed [VAL_W-1:0] sat;
  logic [SIG_IDX_W-1:0]    idx;

  // Saturate to Q4.12, then look up the sigmoid bin
  always_comb begin
    if (acc_i > ACC_W'(32767)) sat = 16'sh7FFF;
    else if (acc_i < -ACC_W'(32768)) sat = -16'sh8000;
    else sat = acc_i[VAL_W-1:0];
    idx = {~sat[VAL_W-1], sat[VAL_W-2 -: SIG_IDX_W-1]};
    act_o = SIG_TABLE[idx];
  end

endmodule

// File: src/mfs_checker.sv
module mfs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input mfs_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mfs_pkg::out_item_t out_data_o
);
  import mfs_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Busy right after a run transaction
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.command == CMD_RUN) |=> in_stall_o)
    else $error("run not taken up");

  // Activation stays within 0..1.0
  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.activation <= ACT_W'(4096)))
    else $error("activation out of range");

  // Transactions other than a run never start a result
  a_wr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_valid_i && !in_stall_o && (in_data_i.command != CMD_RUN)
    |=> !out_valid_o)
    else $error("result without run");

endmodule

bind mlp_forward_sigmoid_core mfs_checker u_mfs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import mfs_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          SETTLE_CYC   = 40;
  localparam logic [1:0]  CMD_NOP      = 2'd3;
  localparam logic [1:0]  LAYER_NONE   = 2'd0;
  localparam logic [1:0]  LAYER_BAD    = 2'd3;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;

  // Forward-pass predictor with its own copy of the stores and counts
  class mlp_predictor;
    logic signed [15:0] weights [2][8][8];
    logic signed [15:0] inputs [8];
    logic signed [15:0] hidden [8];
    logic [3:0]         counts [3];
    logic [12:0]        sig_lut [256];
    out_item_t          expected_acts [$];
    int                 fails;

    function new();
      counts[0] = 4'd3;
      counts[1] = 4'd2;
      counts[2] = 4'd1;
      fails = 0;
      for (int i = 0; i < 256; i++) sig_lut[i] = lut_value(i);
    endfunction

    // exp(-f), Q30 in and out
    function longint unsigned exp_q30(longint unsigned f);
      longint signed   acc;
      longint unsigned term;
      acc  = 1 << 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= 20; k++) begin
        term = (term * f) / (longint'(k) << 30);
        if (k & 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      return (acc < 0) ? 0 : longint'(acc);
    endfunction

    function logic [12:0] lut_value(int i);
      longint signed   x;
      longint unsigned ax, ex, e1, den, num;
      x  = -(64'sd1 <<< 23) + ((longint'(2 * i + 1) <<< 23) / 256);
      ax = (x < 0) ? -x : x;
      ex = exp_q30((ax & 64'hFFFFF) << 10);
      e1 = exp_q30(64'd1 << 30);
      for (longint unsigned k = 0; k < (ax >> 20); k++) ex = (ex * e1) >> 30;
      den = (64'd1 << 30) + ex;
      num = (x >= 0) ? (64'd1 << 42) : (ex << 12);
      return 13'((num + den / 2) / den);
    endfunction

    function int clamp_count(logic [3:0] c);
      if (c == 0) return 1;
      return (c > 8) ? 8 : int'(c);
    endfunction

    function logic signed [15:0] fire(int lyr, int n, logic signed [15:0] src [8], int cnt);
      longint signed acc;
      longint signed idx;
      acc = 0;
      for (int s = 0; s < cnt; s++)
        acc += (longint'(weights[lyr][n][s]) * longint'(src[s])) >>> 12;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      idx = (acc + 32768) >>> 8;
      if (idx > 255) idx = 255;
      return 16'(sig_lut[idx]);
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] val);
      if (idx != REG_UNUSED) counts[idx] = val;
    endfunction

    // Update state for one accepted transaction, queue the activations of a run
    function void note_item(in_item_t it);
      int        ni, nh, no;
      out_item_t r;
      case (it.command)
        CMD_WEIGHT: begin
          if (it.target_layer == LAYER_HIDDEN || it.target_layer == LAYER_OUTPUT)
            weights[it.target_layer - 1][it.neuron_index][it.source_index] = it.value;
        end
        CMD_INPUT: inputs[it.neuron_index] = it.value;
        CMD_RUN: begin
          ni = clamp_count(counts[REG_INPUT_COUNT]);
          nh = clamp_count(counts[REG_HIDDEN_COUNT]);
          no = clamp_count(counts[REG_OUTPUT_COUNT]);
          for (int h = 0; h < nh; h++) hidden[h] = fire(0, h, inputs, ni);
          for (int o = 0; o < no; o++) begin
            r.activation    = 13'(fire(1, o, hidden, nh));
            r.output_neuron = 3'(o);
            r.last          = (o + 1 == no);
            expected_acts.insert(expected_acts.size(), r);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_activation(out_item_t got);
      out_item_t w;
      if (expected_acts.size() == 0) begin
        $error("unexpected result: activation %0d neuron %0d last %0d",
               got.activation, got.output_neuron, got.last);
        fails++;
        return;
      end
      w = expected_acts.pop_front();
      if (got.activation !== w.activation) begin
        $error("activation: expected %0d, actual %0d", w.activation, got.activation);
        fails++;
      end
      if (got.output_neuron !== w.output_neuron) begin
        $error("output_neuron: expected %0d, actual %0d", w.output_neuron, got.output_neuron);
        fails++;
      end
      if (got.last !== w.last) begin
        $error("last: expected %0d, actual %0d", w.last, got.last);
        fails++;
      end
    endfunction
  endclass

  logic       clk_i, rst_ni;
  logic       in_valid_i, in_stall_o;
  in_item_t   in_data_i;
  logic       out_valid_o, out_stall_i;
  out_item_t  out_data_o;
  logic       cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [3:0] cfg_data_i;

  mlp_predictor pred;
  int           cycles;
  int           hold_req;

  mlp_forward_sigmoid_core DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) pred.check_activation(out_data_o);
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stall: random gaps, plus a long hold-off on request
  initial begin
    int stall_left, free_left;
    stall_left = 0;
    free_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        out_stall_i = 1'b0;
        free_left--;
      end else begin
        out_stall_i = 1'b0;
        stall_left  = gap_len();
        free_left   = ($urandom_range(0, 9) == 0) ? 30 : $urandom_range(0, 6);
      end
    end
  end

  task automatic send_item(in_item_t it);
    repeat (gap_len()) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = it;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    pred.note_item(it);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    in_data_i  = $bits(in_item_t)'($urandom);
  endtask

  task automatic send_fields(logic [1:0] cmd, logic [1:0] lyr, logic [2:0] n, logic [2:0] s,
                             logic [15:0] v);
    in_item_t it;
    it.command      = cmd;
    it.target_layer = lyr;
    it.neuron_index = n;
    it.source_index = s;
    it.value        = v;
    send_item(it);
  endtask

  // Wait for all results, then let the block settle
  task automatic drain();
    while (pred.expected_acts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    pred.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 8191)) - 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed loads and runs, some ignored or dropped transactions
  task automatic send_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        send_fields(CMD_WEIGHT, 2'($urandom_range(1, 2)), 3'($urandom), 3'($urandom),
                    rand_value());
      else if (r < 55)
        send_fields(CMD_INPUT, 2'($urandom), 3'($urandom), 3'($urandom), rand_value());
      else if (r < 90)
        send_fields(CMD_RUN, 2'($urandom), 3'($urandom), 3'($urandom), 16'($urandom));
      else if (r < 95)
        send_fields(CMD_NOP, 2'($urandom), 3'($urandom), 3'($urandom), 16'($urandom));
      else
        send_fields(CMD_WEIGHT, ($urandom_range(0, 1) ? LAYER_NONE : LAYER_BAD),
                    3'($urandom), 3'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [3:0] phases [6][3];
    pred        = new();
    cycles      = 0;
    hold_req    = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_INPUT_COUNT;
    cfg_data_i  = '0;
    // Hidden counts stay at 4 or below so only the loaded weights are read
    phases = '{'{4'd8, 4'd4, 4'd8}, '{4'd1, 4'd1, 4'd1}, '{4'd0, 4'd0, 4'd0},
               '{4'd15, 4'd4, 4'd9}, '{4'd5, 4'd3, 4'd7}, '{4'd2, 4'd4, 4'd4}};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Load every store entry that the runs below read
    for (int n = 0; n < 4; n++)
      for (int s = 0; s < 8; s++)
        send_fields(CMD_WEIGHT, LAYER_HIDDEN, 3'(n), 3'(s), rand_value());
    for (int n = 0; n < 8; n++)
      for (int s = 0; s < 4; s++)
        send_fields(CMD_WEIGHT, LAYER_OUTPUT, 3'(n), 3'(s), rand_value());
    for (int s = 0; s < 8; s++) send_fields(CMD_INPUT, 2'($urandom), 3'(s), 3'($urandom),
                                            rand_value());

    // Directed: saturate both ways at reset counts, ignored writes, unused command
    for (int s = 0; s < 3; s++) begin
      send_fields(CMD_INPUT, LAYER_NONE, 3'(s), 3'd0, 16'h7FFF);
      send_fields(CMD_WEIGHT, LAYER_HIDDEN, 3'd0, 3'(s), 16'h7FFF);
      send_fields(CMD_WEIGHT, LAYER_HIDDEN, 3'd1, 3'(s), 16'h7FFF);
    end
    send_fields(CMD_WEIGHT, LAYER_OUTPUT, 3'd0, 3'd0, 16'h8000);
    send_fields(CMD_WEIGHT, LAYER_OUTPUT, 3'd0, 3'd1, 16'h8000);
    send_fields(CMD_WEIGHT, LAYER_NONE, 3'd0, 3'd0, 16'h0123);
    send_fields(CMD_WEIGHT, LAYER_BAD, 3'd0, 3'd1, 16'h4567);
    send_fields(CMD_NOP, LAYER_BAD, 3'd7, 3'd7, 16'hFFFF);
    send_fields(CMD_RUN, LAYER_NONE, 3'd0, 3'd0, 16'h0000);
    send_fields(CMD_INPUT, LAYER_BAD, 3'd7, 3'd7, 16'h8000);
    send_fields(CMD_WEIGHT, LAYER_OUTPUT, 3'd7, 3'd7, 16'h7FFF);
    send_fields(CMD_RUN, LAYER_BAD, 3'd7, 3'd7, 16'hFFFF);
    send_random(6);

    // Walk the count settings, extremes first
    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(REG_INPUT_COUNT, phases[p][0]);
      write_reg(REG_HIDDEN_COUNT, phases[p][1]);
      write_reg(REG_OUTPUT_COUNT, phases[p][2]);
      if (p == 1) write_reg(REG_UNUSED, 4'd1);
      if (p == 0) begin
        // Hold the receiver off while runs keep coming in
        hold_req = 300;
        for (int k = 0; k < 4; k++)
          send_fields(CMD_RUN, LAYER_NONE, 3'd0, 3'd0, 16'($urandom));
      end
      send_random(4);
      if (p == 3) begin
        // Pause the sender until every result is back
        while (pred.expected_acts.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
        send_random(3);
      end
    end

    while (pred.expected_acts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (pred.fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
